/* rtl/aeds_pkg.sv */
`default_nettype none

package aeds_pkg;

  localparam int unsigned LUMA_W  = 8;
  localparam int unsigned GAIN_W  = 10;
  localparam int unsigned EXP_W   = 14;
  localparam int unsigned MEAN_W  = 16;
  localparam int unsigned PROD_W  = 32;
  localparam int unsigned STEP_W  = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 14;

  localparam logic [7:0]        FRAME_INTERVAL = 8'd4;
  localparam logic [STEP_W-1:0] GAIN_STEP      = 10'd8;
  localparam logic [STEP_W-1:0] EXPOSURE_STEP  = 10'd5;

  // Q0.16 luma weights, sum is 65536
  localparam logic [MEAN_W-1:0] W_BLUE  = 16'd7471;
  localparam logic [MEAN_W-1:0] W_GREEN = 16'd38470;
  localparam logic [MEAN_W-1:0] W_RED   = 16'd19595;

  localparam logic [LUMA_W-1:0] TARGET_RST    = 8'd128;
  localparam logic [LUMA_W-1:0] DEADBAND_RST  = 8'd8;
  localparam logic [GAIN_W-1:0] GAIN_FLOOR_RST = 10'd0;
  localparam logic [GAIN_W-1:0] GAIN_CEIL_RST  = 10'd1023;
  localparam logic [EXP_W-1:0]  EXP_FLOOR_RST  = 14'd1;
  localparam logic [EXP_W-1:0]  EXP_CEIL_RST   = 14'd141;
  localparam logic [GAIN_W-1:0] START_GAIN_RST = 10'd512;
  localparam logic [EXP_W-1:0]  START_EXP_RST  = 14'd141;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_LUMA      = 3'd0,
    REG_DEADBAND         = 3'd1,
    REG_GAIN_FLOOR       = 3'd2,
    REG_GAIN_CEILING     = 3'd3,
    REG_EXPOSURE_FLOOR   = 3'd4,
    REG_EXPOSURE_CEILING = 3'd5,
    REG_START_GAIN       = 3'd6,
    REG_START_EXPOSURE   = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    KNOB_GAIN     = 1'b0,
    KNOB_EXPOSURE = 1'b1
  } knob_e;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_blue;
    logic [MEAN_W-1:0] mean_green;
    logic [MEAN_W-1:0] mean_red;
    logic              image_present;
    logic              gain_write_ok;
    logic              exposure_write_ok;
  } stat_t;

  typedef struct packed {
    logic [PROD_W-1:0] prod_blue;
    logic [PROD_W-1:0] prod_green;
    logic [PROD_W-1:0] prod_red;
    logic              image_present;
    logic              gain_write_ok;
    logic              exposure_write_ok;
  } prod_t;

  typedef struct packed {
    logic [EXP_W-1:0]  lo;
    logic [EXP_W-1:0]  hi;
    logic [STEP_W-1:0] step;
  } knob_lim_t;

  typedef struct packed {
    logic             tried;
    logic [EXP_W-1:0] value;
  } knob_res_t;

endpackage

`default_nettype wire

/* rtl/aeds_in_if.sv */
`default_nettype none

interface aeds_in_if;
  logic                        valid;
  logic                        ready;
  logic [aeds_pkg::MEAN_W-1:0] mean_blue;
  logic [aeds_pkg::MEAN_W-1:0] mean_green;
  logic [aeds_pkg::MEAN_W-1:0] mean_red;
  logic                        image_present;
  logic                        gain_write_ok;
  logic                        exposure_write_ok;

  modport source (
    output valid, mean_blue, mean_green, mean_red, image_present, gain_write_ok,
           exposure_write_ok,
    input  ready
  );
  modport sink (
    input  valid, mean_blue, mean_green, mean_red, image_present, gain_write_ok,
           exposure_write_ok,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/aeds_out_if.sv */
`default_nettype none

interface aeds_out_if;
  logic                        valid;
  logic                        ready;
  logic                        evaluated;
  logic [aeds_pkg::LUMA_W-1:0] frame_luma;
  logic                        write_issued;
  logic                        write_knob;
  logic [aeds_pkg::EXP_W-1:0]  write_value;
  logic [aeds_pkg::GAIN_W-1:0] gain_now;
  logic [aeds_pkg::EXP_W-1:0]  exposure_now;

  modport source (
    output valid, evaluated, frame_luma, write_issued, write_knob, write_value,
           gain_now, exposure_now,
    input  ready
  );
  modport sink (
    input  valid, evaluated, frame_luma, write_issued, write_knob, write_value,
           gain_now, exposure_now,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/aeds_knob.sv */
`default_nettype none

// One clamped knob step, up or down.
module aeds_knob (
  input  logic                        up_i,
  input  logic [aeds_pkg::EXP_W-1:0]  cur_i,
  input  aeds_pkg::knob_lim_t         lim_i,
  output aeds_pkg::knob_res_t         res_o
);

  logic [aeds_pkg::EXP_W:0] sum_up;
  logic [aeds_pkg::EXP_W:0] lo_plus;

  assign sum_up  = {1'b0, cur_i} + {5'b0, lim_i.step};
  assign lo_plus = {1'b0, lim_i.lo} + {5'b0, lim_i.step};

  always_comb begin
    if (up_i) begin
      res_o.tried = cur_i < lim_i.hi;
      res_o.value = (sum_up > {1'b0, lim_i.hi}) ? lim_i.hi : sum_up[aeds_pkg::EXP_W-1:0];
    end else begin
      res_o.tried = cur_i > lim_i.lo;
      res_o.value = ({1'b0, cur_i} < lo_plus) ? lim_i.lo
                                              : cur_i - {4'b0, lim_i.step};
    end
  end

endmodule

`default_nettype wire

/* rtl/auto_exposure_deadband_stepper.sv */
`default_nettype none

// Channel   Dir  Fields
// stat_i    in   mean_blue, mean_green, mean_red, image_present,
//                gain_write_ok, exposure_write_ok
// res_o     out  evaluated, frame_luma, write_issued, write_knob,
//                write_value, gain_now, exposure_now
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// One transfer per cycle in, one per cycle out while res_o.ready holds; the result
// passes the input register, product register and result register in turn.
// Knob state updates in the result stage, so consecutive frames see it at once.
// Stages advance independently; a stalled result holds only the stages behind it.
// rst_ni clears valids and frame counter, sets usable flags and loads register defaults.
module auto_exposure_deadband_stepper (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [aeds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [aeds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  aeds_in_if.sink                         stat_i,
  aeds_out_if.source                      res_o
);

  // config
  logic [aeds_pkg::LUMA_W-1:0] target_q, deadband_q;
  logic [aeds_pkg::GAIN_W-1:0] gain_floor_q, gain_ceil_q;
  logic [aeds_pkg::EXP_W-1:0]  exp_floor_q, exp_ceil_q;

  // state
  logic [7:0]                  fc_q, fc_d;
  logic [aeds_pkg::GAIN_W-1:0] gain_q, gain_d;
  logic [aeds_pkg::EXP_W-1:0]  exp_q, exp_d;
  logic                        gain_use_q, gain_use_d;
  logic                        exp_use_q, exp_use_d;

  // pipeline
  aeds_pkg::stat_t s1_q;
  aeds_pkg::prod_t s2_q;
  logic            s1_v_q, s2_v_q, out_v_q;
  logic            rdy1, rdy2, rdy3;

  logic                        ev_q, ev_d;
  logic [aeds_pkg::LUMA_W-1:0] luma_q, luma_d;
  logic                        iss_q, iss_d;
  logic                        knob_q, knob_d;
  logic [aeds_pkg::EXP_W-1:0]  val_q, val_d;

  assign rdy3 = !out_v_q || res_o.ready;
  assign rdy2 = !s2_v_q || rdy3;
  assign rdy1 = !s1_v_q || rdy2;
  assign stat_i.ready = rdy1;

  // result stage logic
  logic [aeds_pkg::PROD_W-1:0] acc;
  logic [aeds_pkg::LUMA_W-1:0] luma;
  logic [7:0]                  fc_inc;
  logic                        too_dark, too_bright;
  aeds_pkg::knob_lim_t         g_lim, e_lim;
  aeds_pkg::knob_res_t         g_res, e_res;

  assign acc    = s2_q.prod_blue + s2_q.prod_green + s2_q.prod_red;
  assign luma   = acc[aeds_pkg::PROD_W-1 -: aeds_pkg::LUMA_W];
  assign fc_inc = fc_q + 8'd1;
  assign too_dark   = ({1'b0, luma} + {1'b0, deadband_q}) < {1'b0, target_q};
  assign too_bright = {1'b0, luma} > ({1'b0, target_q} + {1'b0, deadband_q});

  assign g_lim = '{lo:   {4'b0, gain_floor_q},
                   hi:   {4'b0, gain_ceil_q},
                   step: aeds_pkg::GAIN_STEP};
  assign e_lim = '{lo: exp_floor_q, hi: exp_ceil_q, step: aeds_pkg::EXPOSURE_STEP};

  aeds_knob u_gain (
    .up_i  (too_dark),
    .cur_i ({4'b0, gain_q}),
    .lim_i (g_lim),
    .res_o (g_res)
  );

  aeds_knob u_exp (
    .up_i  (too_dark),
    .cur_i (exp_q),
    .lim_i (e_lim),
    .res_o (e_res)
  );

  always_comb begin
    fc_d       = fc_q;
    gain_d     = gain_q;
    exp_d      = exp_q;
    gain_use_d = gain_use_q;
    exp_use_d  = exp_use_q;
    ev_d       = 1'b0;
    luma_d     = '0;
    iss_d      = 1'b0;
    knob_d     = aeds_pkg::KNOB_GAIN;
    val_d      = '0;
    if (s2_q.image_present) begin
      fc_d = fc_inc;
      if (fc_inc >= aeds_pkg::FRAME_INTERVAL) begin
        fc_d   = '0;
        ev_d   = 1'b1;
        luma_d = luma;
        if (too_dark || too_bright) begin
          if (gain_use_q && g_res.tried) begin
            iss_d = 1'b1;
            val_d = g_res.value;
            if (s2_q.gain_write_ok) gain_d = g_res.value[aeds_pkg::GAIN_W-1:0];
            else gain_use_d = 1'b0;
          end else if (exp_use_q && e_res.tried) begin
            iss_d  = 1'b1;
            knob_d = aeds_pkg::KNOB_EXPOSURE;
            val_d  = e_res.value;
            if (s2_q.exposure_write_ok) exp_d = e_res.value;
            else exp_use_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= aeds_pkg::TARGET_RST;
      deadband_q   <= aeds_pkg::DEADBAND_RST;
      gain_floor_q <= aeds_pkg::GAIN_FLOOR_RST;
      gain_ceil_q  <= aeds_pkg::GAIN_CEIL_RST;
      exp_floor_q  <= aeds_pkg::EXP_FLOOR_RST;
      exp_ceil_q   <= aeds_pkg::EXP_CEIL_RST;
      fc_q         <= '0;
      gain_q       <= aeds_pkg::START_GAIN_RST;
      exp_q        <= aeds_pkg::START_EXP_RST;
      gain_use_q   <= 1'b1;
      exp_use_q    <= 1'b1;
      s1_v_q       <= 1'b0;
      s2_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      if (rdy1) s1_v_q <= stat_i.valid;
      if (rdy2) s2_v_q <= s1_v_q;
      if (rdy3) out_v_q <= s2_v_q;
      if (s2_v_q && rdy3) begin
        fc_q       <= fc_d;
        gain_q     <= gain_d;
        exp_q      <= exp_d;
        gain_use_q <= gain_use_d;
        exp_use_q  <= exp_use_d;
      end
      if (cfg_we_i) begin
        case (aeds_pkg::cfg_idx_e'(cfg_idx_i))
          aeds_pkg::REG_TARGET_LUMA:      target_q     <= cfg_data_i[aeds_pkg::LUMA_W-1:0];
          aeds_pkg::REG_DEADBAND:         deadband_q   <= cfg_data_i[aeds_pkg::LUMA_W-1:0];
          aeds_pkg::REG_GAIN_FLOOR:       gain_floor_q <= cfg_data_i[aeds_pkg::GAIN_W-1:0];
          aeds_pkg::REG_GAIN_CEILING:     gain_ceil_q  <= cfg_data_i[aeds_pkg::GAIN_W-1:0];
          aeds_pkg::REG_EXPOSURE_FLOOR:   exp_floor_q  <= cfg_data_i;
          aeds_pkg::REG_EXPOSURE_CEILING: exp_ceil_q   <= cfg_data_i;
          aeds_pkg::REG_START_GAIN:       gain_q       <= cfg_data_i[aeds_pkg::GAIN_W-1:0];
          aeds_pkg::REG_START_EXPOSURE:   exp_q        <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1 && stat_i.valid) begin
      s1_q.mean_blue         <= stat_i.mean_blue;
      s1_q.mean_green        <= stat_i.mean_green;
      s1_q.mean_red          <= stat_i.mean_red;
      s1_q.image_present     <= stat_i.image_present;
      s1_q.gain_write_ok     <= stat_i.gain_write_ok;
      s1_q.exposure_write_ok <= stat_i.exposure_write_ok;
    end
    if (rdy2 && s1_v_q) begin
      s2_q.prod_blue         <= {16'b0, s1_q.mean_blue} * {16'b0, aeds_pkg::W_BLUE};
      s2_q.prod_green        <= {16'b0, s1_q.mean_green} * {16'b0, aeds_pkg::W_GREEN};
      s2_q.prod_red          <= {16'b0, s1_q.mean_red} * {16'b0, aeds_pkg::W_RED};
      s2_q.image_present     <= s1_q.image_present;
      s2_q.gain_write_ok     <= s1_q.gain_write_ok;
      s2_q.exposure_write_ok <= s1_q.exposure_write_ok;
    end
    if (rdy3 && s2_v_q) begin
      ev_q   <= ev_d;
      luma_q <= luma_d;
      iss_q  <= iss_d;
      knob_q <= knob_d;
      val_q  <= val_d;
    end
  end

  logic [aeds_pkg::GAIN_W-1:0] gain_out_q;
  logic [aeds_pkg::EXP_W-1:0]  exp_out_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && s2_v_q) begin
      gain_out_q <= gain_d;
      exp_out_q  <= exp_d;
    end
  end

  assign res_o.valid        = out_v_q;
  assign res_o.evaluated    = ev_q;
  assign res_o.frame_luma   = luma_q;
  assign res_o.write_issued = iss_q;
  assign res_o.write_knob   = knob_q;
  assign res_o.write_value  = val_q;
  assign res_o.gain_now     = gain_out_q;
  assign res_o.exposure_now = exp_out_q;

  // a knob once rejected stays unusable
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !gain_use_q |=> !gain_use_q) else $error("gain usable flag set again");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exp_use_q |=> !exp_use_q) else $error("exposure usable flag set again");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q < aeds_pkg::FRAME_INTERVAL) else $error("frame counter past interval");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !ev_q |-> !iss_q && luma_q == '0)
    else $error("write or luma on a frame that was not evaluated");

endmodule

`default_nettype wire

/* bench/tb_auto_exposure_deadband_stepper.sv */
`default_nettype none

module tb_auto_exposure_deadband_stepper;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                          evaluated;
    logic [aeds_pkg::LUMA_W-1:0]   frame_luma;
    logic                          write_issued;
    aeds_pkg::knob_e               write_knob;
    logic [aeds_pkg::EXP_W-1:0]    write_value;
    logic [aeds_pkg::GAIN_W-1:0]   gain_now;
    logic [aeds_pkg::EXP_W-1:0]    exposure_now;
  } step_t;

  typedef struct packed {
    logic                            reg_wr;
    aeds_pkg::cfg_idx_e              reg_idx;
    logic [aeds_pkg::CFG_DATA_W-1:0] reg_data;
    aeds_pkg::stat_t                 frame;
    logic                            typed;
    step_t                           want;
  } row_t;

  typedef enum int {SENSOR_OK, GAIN_FLAKY, EXPOSURE_FLAKY} sensor_e;

  localparam int FRAMES_PER_CHECK = 4;
  localparam int GAIN_INC         = 8;
  localparam int EXP_INC          = 5;
  localparam logic [31:0] WEIGHT_B = 32'd7471;
  localparam logic [31:0] WEIGHT_G = 32'd38470;
  localparam logic [31:0] WEIGHT_R = 32'd19595;
  localparam int DRAIN_CYCLES = 8;

  localparam step_t           FROM_MODEL = '0;
  localparam aeds_pkg::stat_t NO_FRAME   = '0;
  localparam aeds_pkg::cfg_idx_e NO_REG  = aeds_pkg::REG_TARGET_LUMA;

  // luma 136 and 119 sit on and just past the deadband edges of the reset setup
  localparam row_t DIRECTED_ROWS [28] = '{
    '{1'b0, NO_REG, 14'd0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1},
      1'b1, '{1'b0, 8'd0, 1'b0, aeds_pkg::KNOB_GAIN, 14'd0, 10'd512, 14'd141}},
    '{1'b0, NO_REG, 14'd0, '{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0},
      1'b0, FROM_MODEL},
    '{1'b0, NO_REG, 14'd0, '{16'hFFFF, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0},
      1'b0, FROM_MODEL},
    '{1'b0, NO_REG, 14'd0, '{16'h0000, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b1},
      1'b0, FROM_MODEL},
    '{1'b0, NO_REG, 14'd0, '{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1},
      1'b1, '{1'b1, 8'd0, 1'b1, aeds_pkg::KNOB_GAIN, 14'd520, 10'd520, 14'd141}},
    '{1'b0, NO_REG, 14'd0, '{16'h0000, 16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0},
      1'b0, FROM_MODEL},
    '{1'b0, NO_REG, 14'd0, '{16'h5555, 16'hAAAA, 16'h5555, 1'b1, 1'b1, 1'b1},
      1'b0, FROM_MODEL},
    '{1'b0, NO_REG, 14'd0, '{16'hAAAA, 16'h5555, 16'hAAAA, 1'b1, 1'b0, 1'b1},
      1'b0, FROM_MODEL},
    '{1'b0, NO_REG, 14'd0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1},
      1'b1, '{1'b1, 8'd255, 1'b1, aeds_pkg::KNOB_GAIN, 14'd512, 10'd512, 14'd141}},
    '{1'b0, NO_REG, 14'd0, '{16'h00FF, 16'hFF00, 16'h00FF, 1'b1, 1'b1, 1'b0},
      1'b0, FROM_MODEL},
    '{1'b0, NO_REG, 14'd0, '{16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0, 1'b0},
      1'b0, FROM_MODEL},
    '{1'b0, NO_REG, 14'd0, '{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1, 1'b1},
      1'b0, FROM_MODEL},
    '{1'b0, NO_REG, 14'd0, '{16'h88FF, 16'h8800, 16'h8880, 1'b1, 1'b1, 1'b1},
      1'b1, '{1'b1, 8'd136, 1'b0, aeds_pkg::KNOB_GAIN, 14'd0, 10'd512, 14'd141}},
    '{1'b0, NO_REG, 14'd0, '{16'h0001, 16'h0001, 16'h0001, 1'b1, 1'b0, 1'b1},
      1'b0, FROM_MODEL},
    '{1'b0, NO_REG, 14'd0, '{16'hFFFE, 16'hFFFE, 16'hFFFE, 1'b1, 1'b1, 1'b0},
      1'b0, FROM_MODEL},
    '{1'b0, NO_REG, 14'd0, '{16'h1234, 16'h5678, 16'h9ABC, 1'b1, 1'b1, 1'b1},
      1'b0, FROM_MODEL},
    '{1'b0, NO_REG, 14'd0, '{16'h7700, 16'h77FF, 16'h7755, 1'b1, 1'b1, 1'b1},
      1'b1, '{1'b1, 8'd119, 1'b1, aeds_pkg::KNOB_GAIN, 14'd520, 10'd520, 14'd141}},
    '{1'b1, aeds_pkg::REG_START_GAIN, 14'd0, NO_FRAME, 1'b0, FROM_MODEL},
    '{1'b0, NO_REG, 14'd0, '{16'hC3C3, 16'h3C3C, 16'hC3C3, 1'b1, 1'b1, 1'b1},
      1'b0, FROM_MODEL},
    '{1'b0, NO_REG, 14'd0, '{16'h0F0F, 16'hF0F0, 16'h0F0F, 1'b1, 1'b0, 1'b0},
      1'b0, FROM_MODEL},
    '{1'b0, NO_REG, 14'd0, '{16'hF00F, 16'h0FF0, 16'hF00F, 1'b1, 1'b1, 1'b1},
      1'b0, FROM_MODEL},
    '{1'b0, NO_REG, 14'd0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1},
      1'b1, '{1'b1, 8'd255, 1'b1, aeds_pkg::KNOB_EXPOSURE, 14'd136, 10'd0, 14'd136}},
    '{1'b1, aeds_pkg::REG_START_GAIN, 14'd1023, NO_FRAME, 1'b0, FROM_MODEL},
    '{1'b0, NO_REG, 14'd0, '{16'h2468, 16'hACE0, 16'h1357, 1'b1, 1'b1, 1'b1},
      1'b0, FROM_MODEL},
    '{1'b0, NO_REG, 14'd0, '{16'h8642, 16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b1},
      1'b0, FROM_MODEL},
    '{1'b0, NO_REG, 14'd0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1},
      1'b1, '{1'b0, 8'd0, 1'b0, aeds_pkg::KNOB_GAIN, 14'd0, 10'd1023, 14'd136}},
    '{1'b0, NO_REG, 14'd0, '{16'h9999, 16'h6666, 16'h3333, 1'b1, 1'b1, 1'b1},
      1'b0, FROM_MODEL},
    '{1'b0, NO_REG, 14'd0, '{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1},
      1'b1, '{1'b1, 8'd0, 1'b1, aeds_pkg::KNOB_EXPOSURE, 14'd141, 10'd1023, 14'd141}}
  };

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [aeds_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [aeds_pkg::CFG_DATA_W-1:0] cfg_data_i;

  aeds_in_if  stat_if ();
  aeds_out_if res_if ();

  auto_exposure_deadband_stepper i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .stat_i     (stat_if),
    .res_o      (res_if)
  );

  // controller state mirror
  logic [7:0]                  tgt_luma, dead_band, frames_seen;
  logic [aeds_pkg::GAIN_W-1:0] gain_lo, gain_hi, gain_cur;
  logic [aeds_pkg::EXP_W-1:0]  exp_lo, exp_hi, exp_cur;
  logic                        gain_live, exp_live;

  step_t pending_steps [$];
  step_t seen_step, wanted_step;
  int    failures;
  bit    calm;

  function automatic aeds_pkg::knob_res_t knob_target(logic up, int cur, int inc, int lo,
                                                      int hi);
    aeds_pkg::knob_res_t k;
    k = '0;
    if (up && cur < hi) begin
      k.tried = 1'b1;
      k.value = aeds_pkg::EXP_W'((cur + inc > hi) ? hi : cur + inc);
    end else if (!up && cur > lo) begin
      k.tried = 1'b1;
      k.value = aeds_pkg::EXP_W'((cur - inc < lo) ? lo : cur - inc);
    end
    return k;
  endfunction

  function automatic step_t advance_controller(aeds_pkg::stat_t f);
    step_t               s;
    aeds_pkg::knob_res_t k;
    logic [31:0]         acc;
    int                  err;
    logic                up;
    s = '0;
    if (f.image_present) begin
      frames_seen = frames_seen + 8'd1;
      if (int'(frames_seen) >= FRAMES_PER_CHECK) begin
        frames_seen = '0;
        acc = WEIGHT_B * 32'(f.mean_blue) + WEIGHT_G * 32'(f.mean_green)
            + WEIGHT_R * 32'(f.mean_red);
        s.evaluated = 1'b1;
        s.frame_luma = acc[31:24];
        err = int'(s.frame_luma) - int'(tgt_luma);
        if (err < -int'(dead_band) || err > int'(dead_band)) begin
          up = (err < 0);
          k = '0;
          if (gain_live) begin
            k = knob_target(up, int'(gain_cur), GAIN_INC, int'(gain_lo), int'(gain_hi));
          end
          if (k.tried) begin
            s.write_issued = 1'b1;
            s.write_knob = aeds_pkg::KNOB_GAIN;
            s.write_value = k.value;
            if (f.gain_write_ok) gain_cur = k.value[aeds_pkg::GAIN_W-1:0];
            else gain_live = 1'b0;
          end else begin
            if (exp_live) begin
              k = knob_target(up, int'(exp_cur), EXP_INC, int'(exp_lo), int'(exp_hi));
            end
            if (k.tried) begin
              s.write_issued = 1'b1;
              s.write_knob = aeds_pkg::KNOB_EXPOSURE;
              s.write_value = k.value;
              if (f.exposure_write_ok) exp_cur = k.value;
              else exp_live = 1'b0;
            end
          end
        end
      end
    end
    s.gain_now = gain_cur;
    s.exposure_now = exp_cur;
    return s;
  endfunction

  function automatic string fmt_step(step_t s);
    return $sformatf("eval=%0d luma=%0d wr=%0d knob=%0d val=%0d gain=%0d exp=%0d",
                     s.evaluated, s.frame_luma, s.write_issued, s.write_knob,
                     s.write_value, s.gain_now, s.exposure_now);
  endfunction

  function automatic int pick(int lo, int hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return int'($urandom_range(hi, lo));
    endcase
  endfunction

  task automatic wait_idle();
    stat_if.valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(aeds_pkg::cfg_idx_e idx, int value);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= aeds_pkg::CFG_DATA_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      aeds_pkg::REG_TARGET_LUMA:      tgt_luma  = 8'(value);
      aeds_pkg::REG_DEADBAND:         dead_band = 8'(value);
      aeds_pkg::REG_GAIN_FLOOR:       gain_lo   = aeds_pkg::GAIN_W'(value);
      aeds_pkg::REG_GAIN_CEILING:     gain_hi   = aeds_pkg::GAIN_W'(value);
      aeds_pkg::REG_EXPOSURE_FLOOR:   exp_lo    = aeds_pkg::EXP_W'(value);
      aeds_pkg::REG_EXPOSURE_CEILING: exp_hi    = aeds_pkg::EXP_W'(value);
      aeds_pkg::REG_START_GAIN:       gain_cur  = aeds_pkg::GAIN_W'(value);
      aeds_pkg::REG_START_EXPOSURE:   exp_cur   = aeds_pkg::EXP_W'(value);
      default: ;
    endcase
  endtask

  task automatic load_setup(int tl, int db, int glo, int ghi, int elo, int ehi,
                            int g0, int e0);
    write_reg(aeds_pkg::REG_TARGET_LUMA, tl);
    write_reg(aeds_pkg::REG_DEADBAND, db);
    write_reg(aeds_pkg::REG_GAIN_FLOOR, glo);
    write_reg(aeds_pkg::REG_GAIN_CEILING, ghi);
    write_reg(aeds_pkg::REG_EXPOSURE_FLOOR, elo);
    write_reg(aeds_pkg::REG_EXPOSURE_CEILING, ehi);
    write_reg(aeds_pkg::REG_START_GAIN, g0);
    write_reg(aeds_pkg::REG_START_EXPOSURE, e0);
  endtask

  task automatic send_frame(aeds_pkg::stat_t f, logic typed, step_t want);
    step_t model;
    if (!calm && $urandom_range(0, 3) == 0) begin
      stat_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    stat_if.valid             <= 1'b1;
    stat_if.mean_blue         <= f.mean_blue;
    stat_if.mean_green        <= f.mean_green;
    stat_if.mean_red          <= f.mean_red;
    stat_if.image_present     <= f.image_present;
    stat_if.gain_write_ok     <= f.gain_write_ok;
    stat_if.exposure_write_ok <= f.exposure_write_ok;
    @(posedge clk_i);
    while (!stat_if.ready) @(posedge clk_i);
    model = advance_controller(f);
    pending_steps.insert(pending_steps.size(), typed ? want : model);
  endtask

  task automatic run_phase(int count, sensor_e sensor);
    aeds_pkg::stat_t f;
    int              shape, span, lvl;
    logic            checked;
    for (int i = 0; i < count; i++) begin
      f.image_present = ($urandom_range(0, 6) != 0);
      checked = f.image_present && (int'(frames_seen) + 1 >= FRAMES_PER_CHECK);
      shape = int'($urandom_range(0, 9));
      if (shape <= 1) begin
        f.mean_blue  = 16'($urandom);
        f.mean_green = 16'($urandom);
        f.mean_red   = 16'($urandom);
      end else begin
        // equal upper bytes give that byte as luma exactly
        span = 2 * int'(dead_band) + 3;
        lvl = int'(tgt_luma) - span + int'($urandom_range(0, 2 * span));
        if (shape == 9) lvl = ($urandom_range(0, 1) != 0) ? 255 : 0;
        if (lvl < 0) lvl = 0;
        if (lvl > 255) lvl = 255;
        f.mean_blue  = {lvl[7:0], 8'($urandom)};
        f.mean_green = {lvl[7:0], 8'($urandom)};
        f.mean_red   = {lvl[7:0], 8'($urandom)};
      end
      if (checked) begin
        f.gain_write_ok     = (sensor == SENSOR_OK) || ($urandom_range(0, 3) != 0);
        f.exposure_write_ok = (sensor != EXPOSURE_FLAKY) || ($urandom_range(0, 3) != 0);
      end else begin
        f.gain_write_ok     = 1'($urandom);
        f.exposure_write_ok = 1'($urandom);
      end
      send_frame(f, 1'b0, FROM_MODEL);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin : res_backpressure
    int stall_left;
    stall_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left = stall_left - 1;
      end else if (!calm && rst_ni && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        stall_left = int'($urandom_range(0, 5));
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen_step.evaluated    = res_if.evaluated;
      seen_step.frame_luma   = res_if.frame_luma;
      seen_step.write_issued = res_if.write_issued;
      seen_step.write_knob   = aeds_pkg::knob_e'(res_if.write_knob);
      seen_step.write_value  = res_if.write_value;
      seen_step.gain_now     = res_if.gain_now;
      seen_step.exposure_now = res_if.exposure_now;
      if (pending_steps.size() == 0) begin
        failures++;
        if (failures <= 10) $display("result transfer with no step pending: %s",
                                     fmt_step(seen_step));
      end else begin
        wanted_step = pending_steps.pop_front();
        if (seen_step !== wanted_step) begin
          failures++;
          if (failures <= 10) $display("step mismatch: expected %s, got %s",
                                       fmt_step(wanted_step), fmt_step(seen_step));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int db;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    stat_if.valid = 1'b0;
    stat_if.mean_blue = '0;
    stat_if.mean_green = '0;
    stat_if.mean_red = '0;
    stat_if.image_present = 1'b0;
    stat_if.gain_write_ok = 1'b0;
    stat_if.exposure_write_ok = 1'b0;
    failures = 0;
    calm = 1'b0;
    tgt_luma = 8'd128;
    dead_band = 8'd8;
    frames_seen = '0;
    gain_lo = 10'd0;
    gain_hi = 10'd1023;
    gain_cur = 10'd512;
    exp_lo = 14'd1;
    exp_hi = 14'd141;
    exp_cur = 14'd141;
    gain_live = 1'b1;
    exp_live = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].reg_wr) begin
        write_reg(DIRECTED_ROWS[i].reg_idx, int'(DIRECTED_ROWS[i].reg_data));
      end else begin
        send_frame(DIRECTED_ROWS[i].frame, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end
    end

    load_setup(128, 8, 0, 1023, 1, 141, 512, 141);
    run_phase(150, SENSOR_OK);
    // pinned dark and bright targets drive both knobs into their limits
    load_setup(0, 0, 1000, 1023, 100, 141, 1023, 141);
    run_phase(100, SENSOR_OK);
    load_setup(255, 0, 0, 40, 1, 10000, 0, 9990);
    run_phase(100, SENSOR_OK);
    calm = 1'b1;
    load_setup(pick(0, 255), 255, 0, 1023, 1, 141, 512, 141);
    run_phase(60, SENSOR_OK);
    calm = 1'b0;
    // floors above ceilings
    load_setup(128, 4, 600, 400, 5000, 100, 396, 50);
    run_phase(100, SENSOR_OK);
    load_setup(128, 6, 0, 0, 1, 10000, 0, 10000);
    run_phase(100, SENSOR_OK);
    repeat (4) begin
      db = ($urandom_range(0, 3) == 0) ? pick(0, 255) : int'($urandom_range(0, 24));
      load_setup(pick(0, 255), db, pick(0, 1023), pick(0, 1023), pick(1, 10000),
                 pick(1, 10000), pick(0, 1023), pick(1, 10000));
      run_phase(110, SENSOR_OK);
    end
    // rejected writes disable a knob until reset, so they come last
    load_setup(128, 8, 0, 1023, 1, 141, 512, 141);
    run_phase(120, GAIN_FLAKY);
    load_setup(128, 10, 0, 1023, 1, 141, 512, 70);
    run_phase(100, SENSOR_OK);
    calm = 1'b1;
    run_phase(100, EXPOSURE_FLAKY);

    wait_idle();
    if (failures == 0 && pending_steps.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
